// ----- rtl/gwo_pkg.sv -----
// Shared types, constants and helper functions of the gyro wheel odometry block.
package gwo_pkg;

	localparam int IN_TDATA_W  = 104;
	localparam int OUT_TDATA_W = 384;

	localparam logic [2:0] REG_LEFT_SCALE  = 3'd0;
	localparam logic [2:0] REG_RIGHT_SCALE = 3'd1;
	localparam logic [2:0] REG_NEG_TURN    = 3'd2;
	localparam logic [2:0] REG_POS_TURN    = 3'd3;
	localparam logic [2:0] REG_CAL_ENABLE  = 3'd4;
	localparam logic [2:0] REG_THRESHOLD   = 3'd5;

	localparam logic [14:0] THRESHOLD_RESET = 15'd10;

	localparam logic [1:0] KIND_SAMPLE     = 2'd0;
	localparam logic [1:0] KIND_SET_YAW    = 2'd1;
	localparam logic [1:0] KIND_CLEAR_SUMS = 2'd2;

	localparam logic signed [32:0] VEL_SCALE = 33'sd15625;

	localparam int CORDIC_STEPS = 30;
	localparam logic [4:0] CORDIC_LAST = 5'(CORDIC_STEPS - 1);
	localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;
	localparam logic signed [33:0] Q30_ONE     = 34'sd1073741824;
	localparam logic signed [35:0] PI_Q30      = 36'sd3373259426;
	localparam logic signed [35:0] HALF_PI_Q30 = 36'sd1686629713;
	localparam logic signed [35:0] TWO_PI_Q30  = 36'sd6746518852;
	localparam logic signed [31:0] PI_Q28      = 32'sd843314857;
	localparam logic signed [31:0] TWO_PI_Q28  = 32'sd1686629713;

	localparam logic signed [35:0] CORDIC_ATAN [CORDIC_STEPS] = '{
		36'sd843314857, 36'sd497837829, 36'sd263043837, 36'sd133525159,
		36'sd67021687, 36'sd33543516, 36'sd16775851, 36'sd8388437,
		36'sd4194283, 36'sd2097149, 36'sd1048576, 36'sd524288, 36'sd262144,
		36'sd131072, 36'sd65536, 36'sd32768, 36'sd16384, 36'sd8192, 36'sd4096,
		36'sd2048, 36'sd1024, 36'sd512, 36'sd256, 36'sd128, 36'sd64, 36'sd32,
		36'sd16, 36'sd8, 36'sd4, 36'sd2
	};

	typedef struct packed {
		logic [31:0] left_scale;
		logic [31:0] right_scale;
		logic [31:0] neg_turn;
		logic [31:0] pos_turn;
		logic        cal_enable;
		logic [14:0] threshold;
	} cfg_t;

	typedef enum logic [3:0] {
		MUL_NONE, MUL_P, MUL_L, MUL_R, MUL_DHI, MUL_DLO, MUL_PHI, MUL_PLO, MUL_X, MUL_Y
	} mul_sel_t;

	typedef enum logic [3:0] {
		WB_NONE, WB_P, WB_DL, WB_DR, WB_NHI, WB_NLO, WB_X, WB_Y, WB_LIN, WB_ANG, WB_BIAS
	} wb_sel_t;

	typedef enum logic [1:0] {DIV_LIN, DIV_ANG, DIV_BIAS} div_sel_t;

	typedef enum logic {ANG_POS, ANG_QUAT} ang_sel_t;

	typedef struct packed {
		logic     capture;
		mul_sel_t mul_sel;
		wb_sel_t  wb_sel;
		logic     yaw_add;
		logic     yaw_wrap;
		logic     yaw_set;
		logic     cal_add;
		logic     cal_clear;
		logic     cordic_start;
		ang_sel_t ang_sel;
		logic     div_start;
		div_sel_t div_sel;
		logic     ram_rd;
		logic     bias_upd;
		logic     out_load;
	} cmd_t;

	typedef struct packed {
		logic [1:0] kind;
		logic       moving;
		logic       cordic_done;
		logic       div_done;
		logic       out_full;
	} sts_t;

	typedef enum logic [4:0] {
		ST_IDLE, ST_DISPATCH, ST_MP, ST_ML, ST_MR, ST_MD,
		ST_LHI, ST_LLO, ST_LADD, ST_LDIV, ST_LWAIT,
		ST_AHI, ST_ALO, ST_AADD, ST_ADIV, ST_AWAIT,
		ST_CSTART, ST_CWAIT, ST_MX, ST_MY, ST_MYW,
		ST_BRD, ST_BUPD, ST_BDIV, ST_BWAIT,
		ST_QSTART, ST_QWAIT, ST_OUT
	} state_t;

	typedef enum logic [2:0] {
		PH_IDLE, PH_REDUCE, PH_FOLD, PH_ITER, PH_FINISH
	} cordic_phase_t;

	function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
		logic signed [63:0] hi;
		logic signed [63:0] lo;
		hi = 64'sd2147483647;
		lo = -64'sd2147483648;
		if (v > hi) return 32'sh7FFFFFFF;
		if (v < lo) return 32'sh80000000;
		return 32'(v);
	endfunction

	function automatic logic signed [47:0] sat48(input logic signed [63:0] v);
		logic signed [63:0] hi;
		logic signed [63:0] lo;
		hi = 64'sd140737488355327;
		lo = -64'sd140737488355328;
		if (v > hi) return 48'sh7FFFFFFFFFFF;
		if (v < lo) return 48'sh800000000000;
		return 48'(v);
	endfunction

endpackage

// ----- rtl/gwo_ram.sv -----
// Generic single-clock RAM with one write port and one registered read port.
module gwo_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ----- rtl/gwo_cordic.sv -----
// Iterative rotation CORDIC giving clamped Q1.30 cosine and sine of a Q5.30 angle.
module gwo_cordic (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic signed [35:0] angle,
	output logic               done,
	output logic signed [31:0] cos_val,
	output logic signed [31:0] sin_val
);

	gwo_pkg::cordic_phase_t phase_q, phase_d;
	logic [4:0]         step_q;
	logic signed [35:0] a_q;
	logic signed [33:0] x_q, y_q;
	logic               neg_q;
	logic               done_q;
	logic signed [33:0] dx, dy, xf, yf;

	assign dx = y_q >>> step_q;
	assign dy = x_q >>> step_q;
	assign xf = neg_q ? -x_q : x_q;
	assign yf = neg_q ? -y_q : y_q;

	always_comb begin
		phase_d = phase_q;
		unique case (phase_q)
			gwo_pkg::PH_IDLE:   if (start) phase_d = gwo_pkg::PH_REDUCE;
			gwo_pkg::PH_REDUCE: phase_d = gwo_pkg::PH_FOLD;
			gwo_pkg::PH_FOLD:   phase_d = gwo_pkg::PH_ITER;
			gwo_pkg::PH_ITER:   if (step_q == gwo_pkg::CORDIC_LAST) phase_d = gwo_pkg::PH_FINISH;
			gwo_pkg::PH_FINISH: phase_d = gwo_pkg::PH_IDLE;
			default:            phase_d = gwo_pkg::PH_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= gwo_pkg::PH_IDLE;
			done_q  <= 1'b0;
		end else begin
			phase_q <= phase_d;
			done_q  <= (phase_q == gwo_pkg::PH_FINISH);
		end
	end

	always_ff @(posedge clk) begin
		unique case (phase_q)
			gwo_pkg::PH_IDLE: begin
				a_q <= angle;
			end
			gwo_pkg::PH_REDUCE: begin
				if (a_q > gwo_pkg::PI_Q30) begin
					a_q <= a_q - gwo_pkg::TWO_PI_Q30;
				end else if (a_q < -gwo_pkg::PI_Q30) begin
					a_q <= a_q + gwo_pkg::TWO_PI_Q30;
				end
			end
			gwo_pkg::PH_FOLD: begin
				if (a_q > gwo_pkg::HALF_PI_Q30) begin
					a_q   <= a_q - gwo_pkg::PI_Q30;
					neg_q <= 1'b1;
				end else if (a_q < -gwo_pkg::HALF_PI_Q30) begin
					a_q   <= a_q + gwo_pkg::PI_Q30;
					neg_q <= 1'b1;
				end else begin
					neg_q <= 1'b0;
				end
				x_q    <= gwo_pkg::CORDIC_GAIN;
				y_q    <= '0;
				step_q <= '0;
			end
			gwo_pkg::PH_ITER: begin
				if (a_q >= 0) begin
					x_q <= x_q - dx;
					y_q <= y_q + dy;
					a_q <= a_q - gwo_pkg::CORDIC_ATAN[step_q];
				end else begin
					x_q <= x_q + dx;
					y_q <= y_q - dy;
					a_q <= a_q + gwo_pkg::CORDIC_ATAN[step_q];
				end
				step_q <= step_q + 5'd1;
			end
			gwo_pkg::PH_FINISH: begin
				if (xf > gwo_pkg::Q30_ONE) cos_val <= 32'(gwo_pkg::Q30_ONE);
				else if (xf < -gwo_pkg::Q30_ONE) cos_val <= 32'(-gwo_pkg::Q30_ONE);
				else cos_val <= 32'(xf);
				if (yf > gwo_pkg::Q30_ONE) sin_val <= 32'(gwo_pkg::Q30_ONE);
				else if (yf < -gwo_pkg::Q30_ONE) sin_val <= 32'(-gwo_pkg::Q30_ONE);
				else sin_val <= 32'(yf);
			end
			default: begin
			end
		endcase
	end

	assign done = done_q;

endmodule

// ----- rtl/gwo_div.sv -----
// Radix-2 restoring divider, truncating toward zero, quotient saturated to 32 bits.
module gwo_div (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic signed [63:0] dividend,
	input  logic [30:0]        divisor,
	output logic               done,
	output logic signed [31:0] quotient
);

	logic        busy_q, done_q, neg_q, ovf_q;
	logic [4:0]  cnt_q;
	logic [62:0] rem_q;
	logic [61:0] dsh_q;
	logic [31:0] quo_q;
	logic [63:0] mag;
	logic        ge;
	logic [31:0] quo_next;

	assign mag      = dividend[63] ? 64'(-dividend) : 64'(dividend);
	assign ge       = rem_q >= {1'b0, dsh_q};
	assign quo_next = {quo_q[30:0], ge};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 5'd1;
				if (cnt_q == 5'd31) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= mag[62:0];
			dsh_q <= {divisor, 31'b0};
			quo_q <= '0;
			neg_q <= dividend[63];
			ovf_q <= mag[62:0] >= {1'b0, divisor, 31'b0};
		end else if (busy_q) begin
			if (ge) begin
				rem_q <= rem_q - {1'b0, dsh_q};
			end
			dsh_q <= dsh_q >> 1;
			quo_q <= quo_next;
			if (cnt_q == 5'd31) begin
				if (ovf_q) quotient <= neg_q ? 32'sh80000000 : 32'sh7FFFFFFF;
				else quotient <= neg_q ? -$signed(quo_next) : $signed(quo_next);
			end
		end
	end

	assign done = done_q;

endmodule

// ----- rtl/gwo_regs.sv -----
// APB configuration register file.
module gwo_regs (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [4:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready,
	output gwo_pkg::cfg_t      cfg
);

	gwo_pkg::cfg_t cfg_q;
	logic [2:0]    idx;
	logic          wr;

	assign idx    = paddr[4:2];
	assign wr     = psel && penable && pwrite;
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.left_scale  <= '0;
			cfg_q.right_scale <= '0;
			cfg_q.neg_turn    <= '0;
			cfg_q.pos_turn    <= '0;
			cfg_q.cal_enable  <= 1'b0;
			cfg_q.threshold   <= gwo_pkg::THRESHOLD_RESET;
		end else if (wr) begin
			unique case (idx)
				gwo_pkg::REG_LEFT_SCALE:  cfg_q.left_scale  <= pwdata;
				gwo_pkg::REG_RIGHT_SCALE: cfg_q.right_scale <= pwdata;
				gwo_pkg::REG_NEG_TURN:    cfg_q.neg_turn    <= pwdata;
				gwo_pkg::REG_POS_TURN:    cfg_q.pos_turn    <= pwdata;
				gwo_pkg::REG_CAL_ENABLE:  cfg_q.cal_enable  <= pwdata[0];
				gwo_pkg::REG_THRESHOLD:   cfg_q.threshold   <= pwdata[14:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			gwo_pkg::REG_LEFT_SCALE:  prdata = cfg_q.left_scale;
			gwo_pkg::REG_RIGHT_SCALE: prdata = cfg_q.right_scale;
			gwo_pkg::REG_NEG_TURN:    prdata = cfg_q.neg_turn;
			gwo_pkg::REG_POS_TURN:    prdata = cfg_q.pos_turn;
			gwo_pkg::REG_CAL_ENABLE:  prdata = {31'b0, cfg_q.cal_enable};
			gwo_pkg::REG_THRESHOLD:   prdata = {17'b0, cfg_q.threshold};
			default:                  prdata = '0;
		endcase
	end

endmodule

// ----- rtl/gwo_datapath.sv -----
// Odometry datapath: state registers, shared multiplier, CORDIC, divider and bias window.
module gwo_datapath #(
	parameter int BIAS_WINDOW = 64
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  gwo_pkg::cfg_t                    cfg,
	input  gwo_pkg::cmd_t                    cmd,
	output gwo_pkg::sts_t                    sts,
	input  logic [gwo_pkg::IN_TDATA_W-1:0]   s_tdata,
	input  logic [1:0]                       s_tuser,
	output logic                             m_tvalid,
	input  logic                             m_tready,
	output logic [gwo_pkg::OUT_TDATA_W-1:0]  m_tdata
);

	localparam int WP_W  = $clog2(BIAS_WINDOW);
	localparam int CNT_W = $clog2(BIAS_WINDOW + 1);
	localparam int SUM_W = 17 + $clog2(BIAS_WINDOW);
	localparam logic [WP_W-1:0]  WP_LAST  = WP_W'(BIAS_WINDOW - 1);
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(BIAS_WINDOW);

	logic [1:0]         kind_q;
	logic signed [15:0] lt_q, rt_q, g_q;
	logic [19:0]        iv_q;
	logic signed [30:0] yaw_in_q;

	logic signed [31:0] pos_x_q, pos_y_q, yaw_q, lin_q, ang_q;
	logic signed [15:0] bias_q;
	logic signed [SUM_W-1:0] bias_sum_q;
	logic [CNT_W-1:0]   cnt_q;
	logic [WP_W-1:0]    wp_q;
	logic signed [47:0] gsum_q, lsum_q, rsum_q;

	logic signed [48:0] p_q, d2_q;
	logic signed [63:0] n_q, prod_q;
	logic               out_valid_q;

	logic signed [16:0] corr;
	logic [16:0]        alt, art;
	logic               moving;
	logic signed [31:0] travel;
	logic signed [32:0] mul_a, mul_b;
	logic signed [65:0] prod;
	logic signed [63:0] yaw_sum;

	logic signed [35:0] cordic_angle;
	logic               cordic_done;
	logic signed [31:0] cos_val, sin_val;

	logic signed [63:0] div_n;
	logic [30:0]        div_d;
	logic               div_done;
	logic signed [31:0] div_q;

	logic [15:0]        ram_rdata;
	logic signed [SUM_W-1:0] g_ext, old_ext;

	assign corr   = 17'(g_q) - 17'(bias_q);
	assign alt    = lt_q[15] ? 17'(-17'(lt_q)) : 17'(lt_q);
	assign art    = rt_q[15] ? 17'(-17'(rt_q)) : 17'(rt_q);
	assign moving = (kind_q == gwo_pkg::KIND_SAMPLE) &&
		((alt > {2'b0, cfg.threshold}) || (art > {2'b0, cfg.threshold}));
	assign travel = 32'(d2_q >>> 17);
	assign yaw_sum = 64'(yaw_q) + 64'(p_q >>> 4);
	assign g_ext   = SUM_W'(g_q);
	assign old_ext = SUM_W'($signed(ram_rdata));

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		unique case (cmd.mul_sel)
			gwo_pkg::MUL_NONE: begin
			end
			gwo_pkg::MUL_P: begin
				mul_a = 33'(corr);
				mul_b = $signed({1'b0, corr[16] ? cfg.neg_turn : cfg.pos_turn});
			end
			gwo_pkg::MUL_L: begin
				mul_a = 33'(lt_q);
				mul_b = $signed({1'b0, cfg.left_scale});
			end
			gwo_pkg::MUL_R: begin
				mul_a = 33'(rt_q);
				mul_b = $signed({1'b0, cfg.right_scale});
			end
			gwo_pkg::MUL_DHI: begin
				mul_a = 33'($signed(d2_q[48:24]));
				mul_b = gwo_pkg::VEL_SCALE;
			end
			gwo_pkg::MUL_DLO: begin
				mul_a = $signed({9'b0, d2_q[23:0]});
				mul_b = gwo_pkg::VEL_SCALE;
			end
			gwo_pkg::MUL_PHI: begin
				mul_a = 33'($signed(p_q[48:24]));
				mul_b = gwo_pkg::VEL_SCALE;
			end
			gwo_pkg::MUL_PLO: begin
				mul_a = $signed({9'b0, p_q[23:0]});
				mul_b = gwo_pkg::VEL_SCALE;
			end
			gwo_pkg::MUL_X: begin
				mul_a = 33'(travel);
				mul_b = 33'(cos_val);
			end
			gwo_pkg::MUL_Y: begin
				mul_a = 33'(travel);
				mul_b = 33'(sin_val);
			end
			default: begin
			end
		endcase
	end

	assign prod = mul_a * mul_b;

	assign cordic_angle = (cmd.ang_sel == gwo_pkg::ANG_POS) ?
		36'(yaw_q) <<< 2 : 36'(yaw_q) <<< 1;

	always_comb begin
		unique case (cmd.div_sel)
			gwo_pkg::DIV_LIN: begin
				div_n = n_q;
				div_d = {iv_q, 11'b0};
			end
			gwo_pkg::DIV_ANG: begin
				div_n = n_q;
				div_d = {1'b0, iv_q, 10'b0};
			end
			gwo_pkg::DIV_BIAS: begin
				div_n = 64'(bias_sum_q);
				div_d = 31'(cnt_q);
			end
			default: begin
				div_n = n_q;
				div_d = {iv_q, 11'b0};
			end
		endcase
	end

	gwo_cordic u_cordic (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (cmd.cordic_start),
		.angle   (cordic_angle),
		.done    (cordic_done),
		.cos_val (cos_val),
		.sin_val (sin_val)
	);

	gwo_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (div_n),
		.divisor  (div_d),
		.done     (div_done),
		.quotient (div_q)
	);

	gwo_ram #(
		.WIDTH (16),
		.DEPTH (BIAS_WINDOW)
	) u_window (
		.clk   (clk),
		.we    (cmd.bias_upd),
		.waddr (wp_q),
		.wdata (g_q),
		.re    (cmd.ram_rd),
		.raddr (wp_q),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk) begin
		prod_q <= prod[63:0];
		if (cmd.capture) begin
			kind_q   <= s_tuser;
			lt_q     <= s_tdata[15:0];
			rt_q     <= s_tdata[31:16];
			g_q      <= s_tdata[47:32];
			iv_q     <= (s_tdata[67:48] == 20'd0) ? 20'd1 : s_tdata[67:48];
			yaw_in_q <= s_tdata[98:68];
		end
		unique case (cmd.wb_sel)
			gwo_pkg::WB_P:   p_q  <= prod_q[48:0];
			gwo_pkg::WB_DL:  d2_q <= prod_q[48:0];
			gwo_pkg::WB_DR:  d2_q <= d2_q + prod_q[48:0];
			gwo_pkg::WB_NHI: n_q  <= prod_q <<< 24;
			gwo_pkg::WB_NLO: n_q  <= n_q + prod_q;
			default: begin
			end
		endcase
		if (cmd.out_load) begin
			m_tdata <= {rsum_q, lsum_q, gsum_q, bias_q, moving, ang_q, lin_q,
				cos_val, sin_val, yaw_q[30:0], pos_y_q, pos_x_q};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_x_q     <= '0;
			pos_y_q     <= '0;
			yaw_q       <= '0;
			lin_q       <= '0;
			ang_q       <= '0;
			bias_q      <= '0;
			bias_sum_q  <= '0;
			cnt_q       <= '0;
			wp_q        <= '0;
			gsum_q      <= '0;
			lsum_q      <= '0;
			rsum_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			unique case (cmd.wb_sel)
				gwo_pkg::WB_X:    pos_x_q <= gwo_pkg::sat32(64'(pos_x_q) + (prod_q >>> 30));
				gwo_pkg::WB_Y:    pos_y_q <= gwo_pkg::sat32(64'(pos_y_q) + (prod_q >>> 30));
				gwo_pkg::WB_LIN:  lin_q   <= div_q;
				gwo_pkg::WB_ANG:  ang_q   <= div_q;
				gwo_pkg::WB_BIAS: bias_q  <= div_q[15:0];
				default: begin
				end
			endcase
			if (cmd.yaw_set) begin
				yaw_q <= 32'(yaw_in_q);
			end else if (cmd.yaw_add) begin
				yaw_q <= gwo_pkg::sat32(yaw_sum);
			end else if (cmd.yaw_wrap) begin
				if (yaw_q >= gwo_pkg::PI_Q28) yaw_q <= yaw_q - gwo_pkg::TWO_PI_Q28;
				else if (yaw_q <= -gwo_pkg::PI_Q28) yaw_q <= yaw_q + gwo_pkg::TWO_PI_Q28;
			end
			if (cmd.cal_clear) begin
				gsum_q <= '0;
				lsum_q <= '0;
				rsum_q <= '0;
			end else if (cmd.cal_add && cfg.cal_enable) begin
				gsum_q <= gwo_pkg::sat48(64'(gsum_q) + 64'(g_q));
				lsum_q <= gwo_pkg::sat48(64'(lsum_q) + 64'(lt_q));
				rsum_q <= gwo_pkg::sat48(64'(rsum_q) + 64'(rt_q));
			end
			if (cmd.bias_upd) begin
				if (cnt_q < CNT_FULL) begin
					bias_sum_q <= bias_sum_q + g_ext;
					cnt_q      <= cnt_q + 1'b1;
				end else begin
					bias_sum_q <= bias_sum_q + g_ext - old_ext;
				end
				wp_q <= (wp_q == WP_LAST) ? '0 : wp_q + 1'b1;
			end
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign m_tvalid        = out_valid_q;
	assign sts.kind        = kind_q;
	assign sts.moving      = moving;
	assign sts.cordic_done = cordic_done;
	assign sts.div_done    = div_done;
	assign sts.out_full    = out_valid_q && !m_tready;

endmodule

// ----- rtl/gwo_ctrl.sv -----
// Sequencing state machine that steps the datapath through one transaction.
module gwo_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          s_tvalid,
	output logic          s_tready,
	input  gwo_pkg::sts_t sts,
	output gwo_pkg::cmd_t cmd
);

	gwo_pkg::state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= gwo_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			gwo_pkg::ST_IDLE:     if (s_tvalid) state_d = gwo_pkg::ST_DISPATCH;
			gwo_pkg::ST_DISPATCH: begin
				priority if (sts.kind == gwo_pkg::KIND_SAMPLE && sts.moving) state_d = gwo_pkg::ST_MP;
				else if (sts.kind == gwo_pkg::KIND_SAMPLE) state_d = gwo_pkg::ST_BRD;
				else state_d = gwo_pkg::ST_QSTART;
			end
			gwo_pkg::ST_MP:     state_d = gwo_pkg::ST_ML;
			gwo_pkg::ST_ML:     state_d = gwo_pkg::ST_MR;
			gwo_pkg::ST_MR:     state_d = gwo_pkg::ST_MD;
			gwo_pkg::ST_MD:     state_d = gwo_pkg::ST_LHI;
			gwo_pkg::ST_LHI:    state_d = gwo_pkg::ST_LLO;
			gwo_pkg::ST_LLO:    state_d = gwo_pkg::ST_LADD;
			gwo_pkg::ST_LADD:   state_d = gwo_pkg::ST_LDIV;
			gwo_pkg::ST_LDIV:   state_d = gwo_pkg::ST_LWAIT;
			gwo_pkg::ST_LWAIT:  if (sts.div_done) state_d = gwo_pkg::ST_AHI;
			gwo_pkg::ST_AHI:    state_d = gwo_pkg::ST_ALO;
			gwo_pkg::ST_ALO:    state_d = gwo_pkg::ST_AADD;
			gwo_pkg::ST_AADD:   state_d = gwo_pkg::ST_ADIV;
			gwo_pkg::ST_ADIV:   state_d = gwo_pkg::ST_AWAIT;
			gwo_pkg::ST_AWAIT:  if (sts.div_done) state_d = gwo_pkg::ST_CSTART;
			gwo_pkg::ST_CSTART: state_d = gwo_pkg::ST_CWAIT;
			gwo_pkg::ST_CWAIT:  if (sts.cordic_done) state_d = gwo_pkg::ST_MX;
			gwo_pkg::ST_MX:     state_d = gwo_pkg::ST_MY;
			gwo_pkg::ST_MY:     state_d = gwo_pkg::ST_MYW;
			gwo_pkg::ST_MYW:    state_d = gwo_pkg::ST_QSTART;
			gwo_pkg::ST_BRD:    state_d = gwo_pkg::ST_BUPD;
			gwo_pkg::ST_BUPD:   state_d = gwo_pkg::ST_BDIV;
			gwo_pkg::ST_BDIV:   state_d = gwo_pkg::ST_BWAIT;
			gwo_pkg::ST_BWAIT:  if (sts.div_done) state_d = gwo_pkg::ST_QSTART;
			gwo_pkg::ST_QSTART: state_d = gwo_pkg::ST_QWAIT;
			gwo_pkg::ST_QWAIT:  if (sts.cordic_done) state_d = gwo_pkg::ST_OUT;
			gwo_pkg::ST_OUT:    if (!sts.out_full) state_d = gwo_pkg::ST_IDLE;
			default:            state_d = gwo_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		cmd         = '0;
		cmd.mul_sel = gwo_pkg::MUL_NONE;
		cmd.wb_sel  = gwo_pkg::WB_NONE;
		cmd.ang_sel = gwo_pkg::ANG_QUAT;
		cmd.div_sel = gwo_pkg::DIV_LIN;
		s_tready    = 1'b0;
		unique case (state_q)
			gwo_pkg::ST_IDLE: begin
				s_tready    = 1'b1;
				cmd.capture = s_tvalid;
			end
			gwo_pkg::ST_DISPATCH: begin
				cmd.yaw_set   = (sts.kind == gwo_pkg::KIND_SET_YAW);
				cmd.cal_clear = (sts.kind == gwo_pkg::KIND_CLEAR_SUMS);
			end
			gwo_pkg::ST_MP: cmd.mul_sel = gwo_pkg::MUL_P;
			gwo_pkg::ST_ML: begin
				cmd.mul_sel = gwo_pkg::MUL_L;
				cmd.wb_sel  = gwo_pkg::WB_P;
			end
			gwo_pkg::ST_MR: begin
				cmd.mul_sel = gwo_pkg::MUL_R;
				cmd.wb_sel  = gwo_pkg::WB_DL;
				cmd.yaw_add = 1'b1;
			end
			gwo_pkg::ST_MD:  cmd.wb_sel = gwo_pkg::WB_DR;
			gwo_pkg::ST_LHI: cmd.mul_sel = gwo_pkg::MUL_DHI;
			gwo_pkg::ST_LLO: begin
				cmd.mul_sel = gwo_pkg::MUL_DLO;
				cmd.wb_sel  = gwo_pkg::WB_NHI;
			end
			gwo_pkg::ST_LADD: cmd.wb_sel = gwo_pkg::WB_NLO;
			gwo_pkg::ST_LDIV: begin
				cmd.div_start = 1'b1;
				cmd.div_sel   = gwo_pkg::DIV_LIN;
			end
			gwo_pkg::ST_LWAIT: if (sts.div_done) cmd.wb_sel = gwo_pkg::WB_LIN;
			gwo_pkg::ST_AHI: cmd.mul_sel = gwo_pkg::MUL_PHI;
			gwo_pkg::ST_ALO: begin
				cmd.mul_sel = gwo_pkg::MUL_PLO;
				cmd.wb_sel  = gwo_pkg::WB_NHI;
			end
			gwo_pkg::ST_AADD: cmd.wb_sel = gwo_pkg::WB_NLO;
			gwo_pkg::ST_ADIV: begin
				cmd.div_start = 1'b1;
				cmd.div_sel   = gwo_pkg::DIV_ANG;
			end
			gwo_pkg::ST_AWAIT: if (sts.div_done) cmd.wb_sel = gwo_pkg::WB_ANG;
			gwo_pkg::ST_CSTART: begin
				cmd.cordic_start = 1'b1;
				cmd.ang_sel      = gwo_pkg::ANG_POS;
			end
			gwo_pkg::ST_CWAIT: begin
			end
			gwo_pkg::ST_MX: cmd.mul_sel = gwo_pkg::MUL_X;
			gwo_pkg::ST_MY: begin
				cmd.mul_sel = gwo_pkg::MUL_Y;
				cmd.wb_sel  = gwo_pkg::WB_X;
			end
			gwo_pkg::ST_MYW: begin
				cmd.wb_sel   = gwo_pkg::WB_Y;
				cmd.yaw_wrap = 1'b1;
				cmd.cal_add  = 1'b1;
			end
			gwo_pkg::ST_BRD:  cmd.ram_rd = 1'b1;
			gwo_pkg::ST_BUPD: cmd.bias_upd = 1'b1;
			gwo_pkg::ST_BDIV: begin
				cmd.div_start = 1'b1;
				cmd.div_sel   = gwo_pkg::DIV_BIAS;
			end
			gwo_pkg::ST_BWAIT: if (sts.div_done) cmd.wb_sel = gwo_pkg::WB_BIAS;
			gwo_pkg::ST_QSTART: begin
				cmd.cordic_start = 1'b1;
				cmd.ang_sel      = gwo_pkg::ANG_QUAT;
			end
			gwo_pkg::ST_QWAIT: begin
			end
			gwo_pkg::ST_OUT: cmd.out_load = !sts.out_full;
			default: begin
			end
		endcase
	end

endmodule

// ----- rtl/gyro_wheel_odometry.sv -----
// Top level of the differential-drive odometry block with gyro heading.
//
//  Channel  Direction  Handshake            Contents
//  s_*      in         s_tvalid / s_tready  one sample, set-yaw or clear-sums item
//  m_*      out        m_tvalid / m_tready  pose, quaternion, velocities, bias, sums
//  APB      in/out     psel / penable       six configuration registers at 4*i
//
// A set-yaw, clear-sums or ignored item goes from acceptance through the 30-step CORDIC
// that produces the quaternion to the result load. A stationary sample adds a bias
// window access and a 32-step pass of the shared divider before that CORDIC run.
// A moving sample runs two divider passes and two CORDIC runs in series.
// Reset clears the pose, velocity, bias, sum and control state at once; the bias window memory needs no clearing.
// A new transaction is taken while a finished result waits in the output register;
// the next result load stalls until that register has been read.
module gyro_wheel_odometry #(
	parameter int BIAS_WINDOW = 64
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	// left_ticks[15:0], right_ticks[31:16], gyro_delta[47:32], interval_us[67:48],
	// yaw_value[98:68], zero fill[103:99]
	input  logic [103:0] s_tdata,
	// kind[1:0]
	input  logic [1:0]   s_tuser,
	output logic         m_tvalid,
	input  logic         m_tready,
	// x_position[31:0], y_position[63:32], heading[94:64], quat_z[126:95],
	// quat_w[158:127], linear_velocity[190:159], angular_velocity[222:191],
	// moving[223], bias_estimate[239:224], gyro_tick_sum[287:240],
	// left_tick_sum[335:288], right_tick_sum[383:336]
	output logic [383:0] m_tdata,
	input  logic         psel,
	input  logic         penable,
	input  logic         pwrite,
	input  logic [4:0]   paddr,
	input  logic [31:0]  pwdata,
	output logic [31:0]  prdata,
	output logic         pready
);

	gwo_pkg::cfg_t cfg;
	gwo_pkg::cmd_t cmd;
	gwo_pkg::sts_t sts;

	gwo_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	gwo_datapath #(
		.BIAS_WINDOW (BIAS_WINDOW)
	) u_datapath (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg),
		.cmd      (cmd),
		.sts      (sts),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	gwo_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

endmodule

// ----- bench/testbench.sv -----
// Self-checking testbench for the gyro wheel odometry block with a built-in pose predictor.
module testbench;

	localparam int WINDOW = 64;
	localparam logic [1:0] KIND_IGNORED = 2'd3;
	localparam int CYCLE_LIMIT = 400000;

	typedef struct {
		logic [1:0]   kind;
		logic [103:0] data;
	} odo_item_t;

	logic         clk;
	logic         arst_n;
	logic         s_tvalid;
	logic         s_tready;
	logic [103:0] s_tdata;
	logic [1:0]   s_tuser;
	logic         m_tvalid;
	logic         m_tready;
	logic [383:0] m_tdata;
	logic         psel;
	logic         penable;
	logic         pwrite;
	logic [4:0]   paddr;
	logic [31:0]  pwdata;
	logic [31:0]  prdata;
	logic         pready;

	odo_item_t      pending_items[$];
	logic [383:0]   expected_poses[$];
	int             sent_count;
	int             taken_count;
	int             result_count;
	int             stalled_count;
	int             in_gap;
	int             out_stall;
	bit             quiet;
	int             errors;
	int             cycles;

	logic [31:0] sh_left_scale;
	logic [31:0] sh_right_scale;
	logic [31:0] sh_neg_turn;
	logic [31:0] sh_pos_turn;
	logic        sh_cal_enable;
	logic [14:0] sh_threshold;

	longint pose_x, pose_y, yaw, lin_vel, ang_vel;
	longint bias_ring[WINDOW];
	longint bias_total, bias;
	int     still_n, ring_ptr;
	longint tick_sums[3];

	gyro_wheel_odometry u_top (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	always begin
		clk = 1'b1;
		#1;
		clk = 1'b0;
		#1;
	end

	function automatic longint clamp(input longint v, input longint lo, input longint hi);
		return v < lo ? lo : (v > hi ? hi : v);
	endfunction

	function automatic void cordic_sincos(input longint a, output longint co, output longint si);
		longint x, y, dx, dy;
		bit neg;
		x = gwo_pkg::CORDIC_GAIN;
		y = 0;
		neg = 0;
		while (a > gwo_pkg::PI_Q30) a -= gwo_pkg::TWO_PI_Q30;
		while (a < -gwo_pkg::PI_Q30) a += gwo_pkg::TWO_PI_Q30;
		if (a > gwo_pkg::HALF_PI_Q30) begin
			a -= gwo_pkg::PI_Q30;
			neg = 1;
		end else if (a < -gwo_pkg::HALF_PI_Q30) begin
			a += gwo_pkg::PI_Q30;
			neg = 1;
		end
		for (int i = 0; i < gwo_pkg::CORDIC_STEPS; i++) begin
			dx = y >>> i;
			dy = x >>> i;
			if (a >= 0) begin
				x -= dx; y += dy; a -= gwo_pkg::CORDIC_ATAN[i];
			end else begin
				x += dx; y -= dy; a += gwo_pkg::CORDIC_ATAN[i];
			end
		end
		if (neg) begin
			x = -x;
			y = -y;
		end
		co = clamp(x, -gwo_pkg::Q30_ONE, gwo_pkg::Q30_ONE);
		si = clamp(y, -gwo_pkg::Q30_ONE, gwo_pkg::Q30_ONE);
	endfunction

	function automatic logic [383:0] odometry_step(input odo_item_t it);
		longint lt, rt, g, iv, corr, p, d2, travel, co, si, qz, qw;
		longint s32_lo, s32_hi, s48_lo, s48_hi;
		logic moving;
		int wp;
		s32_lo = -64'sd2147483648;
		s32_hi = 64'sd2147483647;
		s48_lo = -64'sd140737488355328;
		s48_hi = 64'sd140737488355327;
		lt = longint'($signed(it.data[15:0]));
		rt = longint'($signed(it.data[31:16]));
		g = longint'($signed(it.data[47:32]));
		iv = longint'(it.data[67:48]);
		moving = 1'b0;
		if (iv == 0) iv = 1;
		if (it.kind == gwo_pkg::KIND_SAMPLE) begin
			corr = g - bias;
			if ((lt < 0 ? -lt : lt) > sh_threshold || (rt < 0 ? -rt : rt) > sh_threshold) begin
				moving = 1'b1;
				p = corr * longint'(corr < 0 ? sh_neg_turn : sh_pos_turn);
				d2 = lt * longint'(sh_left_scale) + rt * longint'(sh_right_scale);
				travel = d2 >>> 17;
				yaw = clamp(yaw + (p >>> 4), s32_lo, s32_hi);
				cordic_sincos(yaw * 4, co, si);
				pose_x = clamp(pose_x + ((travel * co) >>> 30), s32_lo, s32_hi);
				pose_y = clamp(pose_y + ((travel * si) >>> 30), s32_lo, s32_hi);
				if (yaw >= gwo_pkg::PI_Q28) yaw -= gwo_pkg::TWO_PI_Q28;
				else if (yaw <= -gwo_pkg::PI_Q28) yaw += gwo_pkg::TWO_PI_Q28;
				lin_vel = clamp((d2 * 15625) / (iv * 2048), s32_lo, s32_hi);
				ang_vel = clamp((p * 15625) / (iv * 1024), s32_lo, s32_hi);
				if (sh_cal_enable) begin
					tick_sums[0] = clamp(tick_sums[0] + g, s48_lo, s48_hi);
					tick_sums[1] = clamp(tick_sums[1] + lt, s48_lo, s48_hi);
					tick_sums[2] = clamp(tick_sums[2] + rt, s48_lo, s48_hi);
				end
			end else begin
				wp = ring_ptr % WINDOW;
				if (still_n < WINDOW) begin
					bias_total += g;
					still_n++;
				end else begin
					bias_total += g - bias_ring[wp];
				end
				bias_ring[wp] = g;
				ring_ptr = (wp + 1) % WINDOW;
				bias = bias_total / longint'(still_n);
			end
		end else if (it.kind == gwo_pkg::KIND_SET_YAW) begin
			yaw = longint'($signed(it.data[98:68]));
		end else if (it.kind == gwo_pkg::KIND_CLEAR_SUMS) begin
			tick_sums[0] = 0;
			tick_sums[1] = 0;
			tick_sums[2] = 0;
		end
		cordic_sincos(yaw * 2, qw, qz);
		return {tick_sums[2][47:0], tick_sums[1][47:0], tick_sums[0][47:0], bias[15:0],
			moving, ang_vel[31:0], lin_vel[31:0], qw[31:0], qz[31:0], yaw[30:0],
			pose_y[31:0], pose_x[31:0]};
	endfunction

	task automatic report(input string field, input logic [47:0] got, input logic [47:0] want);
		$display("mismatch in result %0d, %s: got %h, expected %h", result_count, field, got, want);
		errors++;
	endtask

	task automatic check_pose(input logic [383:0] got, input logic [383:0] want);
		int lo[12];
		int w[12];
		string names[12];
		logic [383:0] mask;
		lo = '{0, 32, 64, 95, 127, 159, 191, 223, 224, 240, 288, 336};
		w = '{32, 32, 31, 32, 32, 32, 32, 1, 16, 48, 48, 48};
		names = '{"x_position", "y_position", "heading", "quat_z", "quat_w", "linear_velocity",
			"angular_velocity", "moving", "bias_estimate", "gyro_tick_sum", "left_tick_sum",
			"right_tick_sum"};
		for (int f = 0; f < 12; f++) begin
			mask = (384'd1 << w[f]) - 384'd1;
			if (((got >> lo[f]) & mask) != ((want >> lo[f]) & mask))
				report(names[f], 48'((got >> lo[f]) & mask), 48'((want >> lo[f]) & mask));
		end
	endtask

	always @(negedge clk) begin
		if (arst_n) begin
			if (!s_tvalid || sent_count == taken_count) begin
				if (in_gap > 0) begin
					in_gap <= in_gap - 1;
					s_tvalid <= 1'b0;
				end else if (pending_items.size() > 0) begin
					odo_item_t it;
					it = pending_items.pop_front();
					s_tdata <= it.data;
					s_tuser <= it.kind;
					s_tvalid <= 1'b1;
					sent_count <= sent_count + 1;
					in_gap <= quiet ? 0 : $urandom_range(0, 4);
				end else begin
					s_tvalid <= 1'b0;
				end
			end
			if (stalled_count != result_count) begin
				stalled_count <= result_count;
				out_stall = quiet ? 0 : $urandom_range(0, 4);
			end
			if (out_stall > 0) begin
				out_stall--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			cycles <= cycles + 1;
			if (cycles > CYCLE_LIMIT) begin
				$display("Verification failed");
				$finish;
			end
			if (s_tvalid && s_tready) begin
				expected_poses.insert(expected_poses.size(),
					odometry_step('{kind: s_tuser, data: s_tdata}));
				taken_count <= taken_count + 1;
			end
			if (m_tvalid && m_tready) begin
				if (expected_poses.size() == 0) begin
					report("unexpected result", m_tdata[47:0], '0);
				end else begin
					check_pose(m_tdata, expected_poses.pop_front());
				end
				result_count <= result_count + 1;
			end
		end
	end

	function automatic odo_item_t make_item(input logic [1:0] kind, input logic [15:0] lt,
			input logic [15:0] rt, input logic [15:0] g, input logic [19:0] iv,
			input logic [30:0] yv);
		odo_item_t it;
		it.kind = kind;
		it.data = {5'b0, yv, iv, g, rt, lt};
		return it;
	endfunction

	task automatic queue_item(input odo_item_t it);
		pending_items.insert(pending_items.size(), it);
	endtask

	task automatic wait_idle();
		while (pending_items.size() != 0 || sent_count != taken_count || s_tvalid
				|| expected_poses.size() != 0)
			@(negedge clk);
		repeat (250) @(negedge clk);
	endtask

	task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
		@(negedge clk);
		psel <= 1'b1;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(negedge clk);
		penable <= 1'b1;
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (idx)
			gwo_pkg::REG_LEFT_SCALE: sh_left_scale = value;
			gwo_pkg::REG_RIGHT_SCALE: sh_right_scale = value;
			gwo_pkg::REG_NEG_TURN: sh_neg_turn = value;
			gwo_pkg::REG_POS_TURN: sh_pos_turn = value;
			gwo_pkg::REG_CAL_ENABLE: sh_cal_enable = value[0];
			gwo_pkg::REG_THRESHOLD: sh_threshold = value[14:0];
			default: ;
		endcase
	endtask

	task automatic add_random(input int n);
		int r;
		logic [15:0] lt, rt, g;
		logic [19:0] iv;
		logic [30:0] yv;
		for (int i = 0; i < n; i++) begin
			if (i % 40 == 0) quiet = ($urandom_range(0, 3) == 0);
			r = $urandom_range(0, 99);
			lt = 16'($urandom);
			rt = 16'($urandom);
			g = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 400) - 200);
			iv = ($urandom_range(0, 1) == 0) ? 20'($urandom) : 20'($urandom_range(0, 5000));
			yv = 31'($signed($urandom_range(0, 1686629714)) - 843314857);
			if (r < 55) begin
				queue_item(make_item(gwo_pkg::KIND_SAMPLE, lt, rt, g, iv, yv));
			end else if (r < 85) begin
				lt = 16'($urandom_range(0, 20) - 10);
				rt = 16'($urandom_range(0, 20) - 10);
				queue_item(make_item(gwo_pkg::KIND_SAMPLE, lt, rt, g, iv, yv));
			end else if (r < 92) begin
				queue_item(make_item(gwo_pkg::KIND_SET_YAW, lt, rt, g, iv, yv));
			end else if (r < 97) begin
				queue_item(make_item(gwo_pkg::KIND_CLEAR_SUMS, lt, rt, g, iv, yv));
			end else begin
				queue_item(make_item(KIND_IGNORED, lt, rt, g, iv, yv));
			end
		end
	endtask

	initial begin
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = '0;
		m_tready = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		sent_count = 0;
		taken_count = 0;
		result_count = 0;
		stalled_count = 0;
		in_gap = 0;
		out_stall = 0;
		quiet = 0;
		errors = 0;
		cycles = 0;
		sh_left_scale = '0;
		sh_right_scale = '0;
		sh_neg_turn = '0;
		sh_pos_turn = '0;
		sh_cal_enable = 1'b0;
		sh_threshold = gwo_pkg::THRESHOLD_RESET;
		pose_x = 0; pose_y = 0; yaw = 0; lin_vel = 0; ang_vel = 0;
		bias_total = 0; bias = 0; still_n = 0; ring_ptr = 0;
		tick_sums[0] = 0; tick_sums[1] = 0; tick_sums[2] = 0;
		foreach (bias_ring[i]) bias_ring[i] = 0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		queue_item(make_item(gwo_pkg::KIND_SAMPLE, 16'd100, 16'd100, 16'd50, 20'd1000, '0));
		wait_idle();
		write_reg(gwo_pkg::REG_LEFT_SCALE, 32'hFFFFFFFF);
		write_reg(gwo_pkg::REG_RIGHT_SCALE, 32'hFFFFFFFF);
		write_reg(gwo_pkg::REG_NEG_TURN, 32'hFFFFFFFF);
		write_reg(gwo_pkg::REG_POS_TURN, 32'hFFFFFFFF);
		write_reg(gwo_pkg::REG_CAL_ENABLE, 32'd1);
		write_reg(gwo_pkg::REG_THRESHOLD, 32'd0);
		queue_item(make_item(gwo_pkg::KIND_SAMPLE, 16'h7FFF, 16'h7FFF, 16'h7FFF, 20'd0, '0));
		queue_item(make_item(gwo_pkg::KIND_SAMPLE, 16'h8000, 16'h8000, 16'h8000, 20'hFFFFF,
			'0));
		queue_item(make_item(gwo_pkg::KIND_SAMPLE, 16'h7FFF, 16'h8000, 16'h0000, 20'd1, '0));
		queue_item(make_item(gwo_pkg::KIND_SAMPLE, 16'd0, 16'd0, 16'h7FFF, 20'd1, '0));
		queue_item(make_item(gwo_pkg::KIND_SAMPLE, 16'd0, 16'd0, 16'h8000, 20'd7, '0));
		queue_item(make_item(gwo_pkg::KIND_SET_YAW, 16'h8000, 16'h7FFF, 16'hFFFF, 20'hFFFFF,
			31'sd843314857));
		queue_item(make_item(gwo_pkg::KIND_SAMPLE, 16'd1, 16'hFFFF, 16'd1, 20'd3, '0));
		queue_item(make_item(gwo_pkg::KIND_SET_YAW, '0, '0, '0, 20'd0, -31'sd843314857));
		queue_item(make_item(gwo_pkg::KIND_SAMPLE, 16'hFFFF, 16'd1, 16'hFFFF, 20'd3, '0));
		queue_item(make_item(gwo_pkg::KIND_SET_YAW, '0, '0, '0, 20'd5, 31'sd421657428));
		queue_item(make_item(gwo_pkg::KIND_CLEAR_SUMS, 16'h7FFF, '0, '0, 20'd5, '0));
		queue_item(make_item(KIND_IGNORED, 16'h7FFF, 16'h7FFF, 16'h7FFF, 20'd9,
			31'sd1000));
		queue_item(make_item(gwo_pkg::KIND_SET_YAW, '0, '0, '0, 20'd5, -31'sd421657428));
		queue_item(make_item(gwo_pkg::KIND_SAMPLE, 16'h4000, 16'hC000, 16'h1234, 20'd20, '0));
		add_random(100);
		wait_idle();
		write_reg(gwo_pkg::REG_THRESHOLD, 32'd32767);
		write_reg(gwo_pkg::REG_CAL_ENABLE, 32'd0);
		add_random(60);
		wait_idle();
		write_reg(gwo_pkg::REG_LEFT_SCALE, 32'd281475);
		write_reg(gwo_pkg::REG_RIGHT_SCALE, 32'd281000);
		write_reg(gwo_pkg::REG_NEG_TURN, 32'd4000000);
		write_reg(gwo_pkg::REG_POS_TURN, 32'd4100000);
		write_reg(gwo_pkg::REG_THRESHOLD, 32'd10);
		write_reg(gwo_pkg::REG_CAL_ENABLE, 32'd1);
		add_random(150);
		wait_idle();
		write_reg(gwo_pkg::REG_LEFT_SCALE, $urandom);
		write_reg(gwo_pkg::REG_RIGHT_SCALE, $urandom);
		write_reg(gwo_pkg::REG_NEG_TURN, $urandom);
		write_reg(gwo_pkg::REG_POS_TURN, $urandom);
		write_reg(gwo_pkg::REG_THRESHOLD, 32'd1);
		add_random(130);
		wait_idle();
		if (errors == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end
endmodule

// ----- files.f -----
rtl/gwo_pkg.sv
rtl/gwo_ram.sv
rtl/gwo_cordic.sv
rtl/gwo_div.sv
rtl/gwo_regs.sv
rtl/gwo_datapath.sv
rtl/gwo_ctrl.sv
rtl/gyro_wheel_odometry.sv
bench/testbench.sv
